// ===== sv/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants of the software timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int SLOTS  = 32;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int TIME_W = 32;
  localparam int HID_W  = 8;
  localparam int SLOT_W = 5;

  typedef enum logic [1:0] {
    REQ_REGISTER   = 2'd0,
    REQ_DEREGISTER = 2'd1,
    REQ_TICK       = 2'd2,
    REQ_REAP       = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_REGISTERED = 2'd0,
    KIND_FULL       = 2'd1,
    KIND_FIRED      = 2'd2,
    KIND_DONE       = 2'd3
  } kind_e;

  // One timer slot as held in memory.
  typedef struct packed {
    logic [TIME_W-1:0] fire_time;
    logic [TIME_W-1:0] reload;
    logic [HID_W-1:0]  owner;
  } slot_ent_t;

  // Write port bundle into the slot memory.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    slot_ent_t        data;
  } mem_wr_t;

endpackage

// ===== sv/stt_slot_mem.sv =====
// ----------------------------------------------------------------------------
// stt_slot_mem
// Slot memory with registered read and per-entry valid bits; an entry never
// written since reset reads as all zero.
// ----------------------------------------------------------------------------
module stt_slot_mem (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rd_en_i,
  input  logic [stt_pkg::IDX_W-1:0] rd_addr_i,
  output stt_pkg::slot_ent_t      rd_data_o,
  input  stt_pkg::mem_wr_t        wr_i
);
  import stt_pkg::*;

  slot_ent_t        mem [SLOTS];
  logic [SLOTS-1:0] vld_q;
  slot_ent_t        rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== sv/software_timer_table.sv =====
// ----------------------------------------------------------------------------
// software_timer_table
// Table of timer slots: register, deregister, tick and reap requests.
// ----------------------------------------------------------------------------
// Each request scans every slot of the slot memory in order, one slot read
// per cycle while the result stream does not stall, and writes a modified
// slot back once its read data is processed. Register and tick end with a
// finish step after the scan; deregister and reap go back to idle straight
// from the scan. The scan is paced by the single read port of the slot
// memory and is held whenever the result stream stalls. Register returns one
// result (registered with slot, or full); tick returns one fired result per
// due slot, then done with tlast. Deregister and reap return nothing. After
// reset every slot reads as free at once, with no clearing pass.
module software_timer_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  // request stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [103:0] s_axis_tdata_i,  // now_tick[31:0], delay, repeat_interval,
                                        // handler_id[7:0]
  input  logic [1:0]   s_axis_tuser_i,  // req_type[1:0]
  // result stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [15:0]  m_axis_tdata_o,  // slot[4:0], fired_handler[7:0], zero pad
  output logic [1:0]   m_axis_tuser_o,  // result_kind[1:0]
  output logic         m_axis_tlast_o
);
  import stt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e st_q, st_d;

  // captured request
  req_e              req_q;
  logic [TIME_W-1:0] now_q, dly_q, rep_q;
  logic [HID_W-1:0]  hid_q;

  // scan pipeline: read issue, then process
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              proc_vld_q, proc_vld_d;
  logic [IDX_W-1:0]  proc_idx_q, proc_idx_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;

  // result register
  logic              out_vld_q, out_vld_d;
  kind_e             out_kind_q, out_kind_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [HID_W-1:0]  out_hid_q, out_hid_d;
  logic              out_last_q, out_last_d;

  logic              s_acc;
  logic              adv;       // result register can take a new transaction
  logic              rd_en;
  logic              scan_end;
  slot_ent_t         ent;
  mem_wr_t           wr;

  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign adv             = !out_vld_q || m_axis_tready_i;
  assign scan_end        = (rd_idx_q == CNT_W'(SLOTS));
  assign rd_en           = (st_q == ST_SCAN) && adv && !scan_end;

  stt_slot_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q[IDX_W-1:0]),
    .rd_data_o (ent),
    .wr_i      (wr)
  );

  always_comb begin
    st_d       = st_q;
    rd_idx_d   = rd_idx_q;
    proc_vld_d = proc_vld_q;
    proc_idx_d = proc_idx_q;
    found_d    = found_q;
    hit_idx_d  = hit_idx_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_kind_d = out_kind_q;
    out_slot_d = out_slot_q;
    out_hid_d  = out_hid_q;
    out_last_d = out_last_q;
    wr         = '0;
    wr.addr    = proc_idx_q;
    wr.data    = ent;

    case (st_q)
      ST_IDLE: begin
        if (s_acc) begin
          st_d       = ST_SCAN;
          rd_idx_d   = '0;
          proc_vld_d = 1'b0;
          found_d    = 1'b0;
          hit_idx_d  = '0;
        end
      end
      ST_SCAN: begin
        if (adv) begin
          // process the slot whose read data just arrived
          if (proc_vld_q) begin
            case (req_q)
              REQ_REGISTER: begin
                if (!found_q && ent.fire_time == '0) begin
                  wr.we             = 1'b1;
                  wr.data.fire_time = TIME_W'(now_q + dly_q);
                  wr.data.reload    = rep_q;
                  wr.data.owner     = hid_q;
                  found_d           = 1'b1;
                  hit_idx_d         = proc_idx_q;
                end
              end
              REQ_DEREGISTER: begin
                if (!found_q && hid_q != '0 && ent.owner == hid_q) begin
                  wr.we     = 1'b1;
                  wr.data   = '0;
                  found_d   = 1'b1;
                end
              end
              REQ_TICK: begin
                if (ent.fire_time != '0 && ent.fire_time == now_q) begin
                  out_vld_d  = 1'b1;
                  out_kind_d = KIND_FIRED;
                  out_slot_d = SLOT_W'(proc_idx_q);
                  out_hid_d  = ent.owner;
                  out_last_d = 1'b0;
                  if (ent.reload != '0) begin
                    wr.we             = 1'b1;
                    wr.data.fire_time = TIME_W'(now_q + ent.reload);
                  end
                end
              end
              REQ_REAP: begin
                if (ent.fire_time != '0 && ent.fire_time < now_q) begin
                  wr.we   = 1'b1;
                  wr.data = '0;
                end
              end
              default: ;
            endcase
          end
          // issue the next read
          proc_vld_d = !scan_end;
          proc_idx_d = rd_idx_q[IDX_W-1:0];
          if (!scan_end) begin
            rd_idx_d = rd_idx_q + CNT_W'(1);
          end else if (req_q == REQ_REGISTER || req_q == REQ_TICK) begin
            st_d = ST_FINISH;
          end else begin
            st_d = ST_IDLE;
          end
        end
      end
      ST_FINISH: begin
        if (adv) begin
          out_vld_d  = 1'b1;
          out_hid_d  = '0;
          out_last_d = 1'b1;
          if (req_q == REQ_TICK) begin
            out_kind_d = KIND_DONE;
            out_slot_d = '0;
          end else begin
            out_kind_d = found_q ? KIND_REGISTERED : KIND_FULL;
            out_slot_d = found_q ? SLOT_W'(hit_idx_q) : '0;
          end
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      rd_idx_q   <= '0;
      proc_vld_q <= 1'b0;
      found_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      st_q       <= st_d;
      rd_idx_q   <= rd_idx_d;
      proc_vld_q <= proc_vld_d;
      found_q    <= found_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      req_q <= req_e'(s_axis_tuser_i);
      now_q <= s_axis_tdata_i[31:0];
      dly_q <= s_axis_tdata_i[63:32];
      rep_q <= s_axis_tdata_i[95:64];
      hid_q <= s_axis_tdata_i[103:96];
    end
    proc_idx_q <= proc_idx_d;
    hit_idx_q  <= hit_idx_d;
    out_kind_q <= out_kind_d;
    out_slot_q <= out_slot_d;
    out_hid_q  <= out_hid_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {3'b000, out_hid_q, out_slot_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // only a fired result leaves the transaction open
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o != KIND_FIRED)))
    else $error("tlast does not match result kind");

  // an accepted request starts a scan at slot zero
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (st_q == ST_SCAN && rd_idx_q == '0 && !proc_vld_q))
    else $error("scan did not start at slot zero");

  // the scan ends only with the last slot still to process
  a_scan_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCAN && scan_end) |-> proc_vld_q)
    else $error("scan end without pending slot");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the software timer table.
// ----------------------------------------------------------------------------
// Requests go in on the slave stream and results come out on the master
// stream. Both sides idle and stall at random. An in-bench copy of the slot
// table works out the results of every accepted request; the checker
// compares each result transaction, field by field, with the oldest
// expected one. Directed cases come first, then a table fill, then random
// traffic that mostly follows a running time base so that timers fire.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import stt_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;  // far above the slowest correct run
  localparam int IDLE_PCT    = 33;

  // one expected result transaction
  typedef struct {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic [HID_W-1:0]  handler;
    logic              last;
  } timer_result_t;

  logic         clk_i;
  logic         rst_ni          = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [103:0] s_axis_tdata_i  = '0;  // now_tick, delay, repeat_interval, handler_id
  logic [1:0]   s_axis_tuser_i  = REQ_TICK;  // req_type
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [15:0]  m_axis_tdata_o;  // slot, fired_handler, zero pad
  logic [1:0]   m_axis_tuser_o;  // result_kind
  logic         m_axis_tlast_o;

  // bench copy of the slot table
  logic [TIME_W-1:0] fire_at  [SLOTS];
  logic [TIME_W-1:0] reload_by[SLOTS];
  logic [HID_W-1:0]  owned_by [SLOTS];

  timer_result_t awaited_results[$];
  int            error_count = 0;
  int            cycle_count = 0;
  bit            no_idle     = 1'b0;  // stretch with no idling on either side

  software_timer_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side backpressure.
  always @(posedge clk_i) begin
    m_axis_tready_i <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  function automatic void queue_result(input kind_e kind, input int slot,
                                       input logic [HID_W-1:0] handler, input logic last);
    timer_result_t r;
    r.kind    = kind;
    r.slot    = SLOT_W'(slot);
    r.handler = handler;
    r.last    = last;
    awaited_results.push_back(r);
  endfunction

  function automatic void clear_timer(input int s);
    fire_at[s]   = '0;
    reload_by[s] = '0;
    owned_by[s]  = '0;
  endfunction

  // Applies one request to the bench table and queues what it returns.
  function automatic void timer_table_step(input req_e req, input logic [TIME_W-1:0] now,
                                           input logic [TIME_W-1:0] dly,
                                           input logic [TIME_W-1:0] rep,
                                           input logic [HID_W-1:0] hid);
    bit done_search;
    done_search = 1'b0;
    case (req)
      REQ_REGISTER: begin
        // lowest free slot; a fire time that wraps to zero leaves it free
        for (int s = 0; s < SLOTS && !done_search; s++) begin
          if (fire_at[s] == '0) begin
            fire_at[s]   = now + dly;
            reload_by[s] = rep;
            owned_by[s]  = hid;
            queue_result(KIND_REGISTERED, s, '0, 1'b1);
            done_search  = 1'b1;
          end
        end
        if (!done_search) queue_result(KIND_FULL, 0, '0, 1'b1);
      end
      REQ_DEREGISTER: begin
        // free slots are searched too; handler zero is a no-op
        if (hid != '0) begin
          for (int s = 0; s < SLOTS && !done_search; s++) begin
            if (owned_by[s] == hid) begin
              clear_timer(s);
              done_search = 1'b1;
            end
          end
        end
      end
      REQ_TICK: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (fire_at[s] != '0 && fire_at[s] == now) begin
            queue_result(KIND_FIRED, s, owned_by[s], 1'b0);
            if (reload_by[s] != '0) fire_at[s] = now + reload_by[s];
          end
        end
        queue_result(KIND_DONE, 0, '0, 1'b1);
      end
      default: begin  // reap
        for (int s = 0; s < SLOTS; s++) begin
          if (fire_at[s] != '0 && fire_at[s] < now) clear_timer(s);
        end
      end
    endcase
  endfunction

  // Drives one request, holds it until accepted, then predicts it.
  task automatic send_request(input req_e req, input logic [TIME_W-1:0] now,
                              input logic [TIME_W-1:0] dly,
                              input logic [TIME_W-1:0] rep,
                              input logic [HID_W-1:0] hid);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {hid, rep, dly, now};
    s_axis_tuser_i  <= req;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    timer_table_step(req, now, dly, rep, hid);
  endtask

  // Sender goes quiet until every expected result is back.
  task automatic wait_until_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // Result checker.
  always @(posedge clk_i) begin : result_check
    timer_result_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result, kind", m_axis_tuser_o, 0);
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tuser_o != want.kind)
          report_mismatch("result_kind", m_axis_tuser_o, want.kind);
        if (m_axis_tdata_o[SLOT_W-1:0] != want.slot)
          report_mismatch("slot", m_axis_tdata_o[SLOT_W-1:0], want.slot);
        if (m_axis_tdata_o[SLOT_W +: HID_W] != want.handler)
          report_mismatch("fired_handler", m_axis_tdata_o[SLOT_W +: HID_W], want.handler);
        if (m_axis_tlast_o != want.last)
          report_mismatch("last", m_axis_tlast_o, want.last);
      end
    end
  end

  // Hand-picked sequence; comments track the table contents.
  task automatic test_directed_cases();
    send_request(REQ_TICK,     32'd0,          '0, '0, 8'h00);  // empty table: done only
    send_request(REQ_REAP,     32'hFFFF_FFFF,  '0, '0, 8'h00);
    send_request(REQ_REGISTER, 32'd100, 32'd5, 32'd0, 8'hFF);   // slot 0, one shot at 105
    send_request(REQ_REGISTER, 32'd100, 32'd5, 32'd3, 8'h01);   // slot 1, repeats every 3
    // fire time wraps to zero: slot 2 written but stays free
    send_request(REQ_REGISTER, 32'hFFFF_FFFF, 32'd1, 32'd0, 8'h80);
    send_request(REQ_REGISTER, 32'hFFFF_FFF0, 32'd0, 32'h10, 8'h09);  // slot 2 again
    send_request(REQ_REGISTER, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h09);  // slot 3
    send_request(REQ_TICK,     32'd105, '0, '0, 8'h00);  // slots 0 and 1 fire
    send_request(REQ_TICK,     32'd105, '0, '0, 8'h00);  // one shot fires again
    send_request(REQ_TICK,     32'd108, '0, '0, 8'h00);  // reloaded slot 1
    // reload wraps to zero: slot 2 goes free but keeps owner 9
    send_request(REQ_TICK,     32'hFFFF_FFF0, '0, '0, 8'h00);
    send_request(REQ_DEREGISTER, '0, '0, '0, 8'h09);      // hits free slot 2, not slot 3
    send_request(REQ_TICK,     32'hFFFF_FFFF, '0, '0, 8'h00);  // slot 3 still fires
    send_request(REQ_DEREGISTER, '0, '0, '0, 8'h00);      // handler zero: no-op
    send_request(REQ_DEREGISTER, '0, '0, '0, 8'h55);      // no owner
    send_request(REQ_REAP,     32'd111, '0, '0, 8'h00);   // clears slot 0, slot 1 equal stays
    send_request(REQ_TICK,     32'd111, '0, '0, 8'h00);
    send_request(REQ_REGISTER, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 8'h2A);  // slot 0
    send_request(REQ_REAP,     32'hFFFF_FFFF, '0, '0, 8'h00);
    send_request(REQ_TICK,     32'hFFFF_FFFF, '0, '0, 8'h00);
    send_request(REQ_DEREGISTER, '0, '0, '0, 8'h2A);
  endtask

  // Fill every slot, overflow once, then empty it again.
  task automatic test_table_full();
    logic [TIME_W-1:0] base;
    base = $urandom_range(1, 32'h00FF_FFFF);
    for (int i = 0; i <= SLOTS; i++) begin
      send_request(REQ_REGISTER, base, TIME_W'($urandom_range(1, 40)),
                   TIME_W'($urandom_range(0, 3)), HID_W'($urandom_range(1, 255)));
    end
    send_request(REQ_TICK, base + 32'd1, '0, '0, 8'h00);
    send_request(REQ_REAP, 32'hFFFF_FFFF, '0, '0, 8'h00);
  endtask

  // Mostly well-formed timer traffic around a running time base, some noise.
  task automatic test_random_traffic(input int count);
    logic [TIME_W-1:0] clock_now;
    logic [TIME_W-1:0] dly;
    logic [TIME_W-1:0] rep;
    logic [HID_W-1:0]  hid;
    logic [HID_W-1:0]  recent_hid[8];
    int                pick;
    clock_now = $urandom_range(1, 1000);
    foreach (recent_hid[i]) recent_hid[i] = HID_W'($urandom_range(1, 255));
    for (int n = 0; n < count; n++) begin
      no_idle = (n >= count / 3) && (n < count / 3 + 80);
      if (n == count / 2) wait_until_drained();
      if (n % 60 == 59) clock_now = $urandom_range(1) ? $urandom() : 32'hFFFF_FFF8;
      pick = $urandom_range(99);
      if (pick < 35) begin
        dly = ($urandom_range(9) == 0) ? $urandom() : TIME_W'($urandom_range(0, 12));
        case ($urandom_range(3))
          0, 1:    rep = '0;
          2:       rep = TIME_W'($urandom_range(1, 6));
          default: rep = ($urandom_range(3) == 0) ? $urandom() : TIME_W'($urandom_range(1, 20));
        endcase
        hid = HID_W'($urandom_range(0, 255));
        recent_hid[$urandom_range(7)] = hid;
        send_request(REQ_REGISTER, clock_now, dly, rep, hid);
      end else if (pick < 75) begin
        send_request(REQ_TICK, clock_now, $urandom(), $urandom(), HID_W'($urandom()));
        clock_now = clock_now + 32'd1;
      end else if (pick < 85) begin
        send_request(REQ_REAP,
                     ($urandom_range(9) < 3) ? 32'hFFFF_FFFF : clock_now - $urandom_range(0, 5),
                     '0, '0, 8'h00);
      end else if (pick < 94) begin
        hid = $urandom_range(1) ? recent_hid[$urandom_range(7)] : HID_W'($urandom_range(0, 255));
        send_request(REQ_DEREGISTER, clock_now, '0, '0, hid);
      end else begin
        send_request(req_e'(2'($urandom_range(3))), $urandom(), $urandom(), $urandom(),
                     HID_W'($urandom()));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    foreach (fire_at[i]) clear_timer(i);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_table_full();
    test_random_traffic(325);

    // let the last requests finish, including ones that return nothing
    wait_until_drained();
    repeat (4 * SLOTS) @(posedge clk_i);

    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (awaited_results.size() != 0)
        report_mismatch("results never returned", 0, awaited_results.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/stt_pkg.sv
sv/stt_slot_mem.sv
sv/software_timer_table.sv
dv/testbench.sv
